// ===== design/sfr_pkg.sv =====
package sfr_pkg;

    // Sample and phase formats.
    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int MAX_RATIO       = 24;
    localparam int ONE_Q           = 2 ** PHASE_FRAC_BITS;
    localparam int MIN_STEP        = (ONE_Q + MAX_RATIO - 1) / MAX_RATIO;

    // Register and state widths.
    localparam int PHASE_W = PHASE_FRAC_BITS + 1;
    localparam int STEP_W  = 21;
    localparam int INV_W   = 17;
    localparam int REM_W   = STEP_W + 1;
    localparam int ACC_W   = 40;

    // Shared multiplier: the accumulator is split into a low unsigned part
    // and a high signed part so that each partial product fits the unit.
    localparam int ACC_SPLIT = 20;
    localparam int MUL_A_W   = ACC_W - ACC_SPLIT + 1;
    localparam int MUL_B_W   = PHASE_W + 1;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int WIDE_W    = MUL_P_W + ACC_SPLIT;
    localparam int SAT_W     = WIDE_W - 2 * PHASE_FRAC_BITS;

    // Saturation bounds.
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(2 ** (SAMPLE_BITS - 1));

    // Reset values of the configuration registers.
    localparam int STEP_RESET = 65536;
    localparam int INV_RESET  = 65536;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOWN_MODE  = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_INV_STEP   = 2'd2
    } t_cfg_idx;

    // Input word kinds.
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

endpackage

// ===== design/sfr_if.sv =====
// Input channel: one stereo pair or a restart per word.
interface sfr_in_if import sfr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output kind, output in_left, output in_right,
                    input ready);
    modport sink   (input valid, input kind, input in_left, input in_right,
                    output ready);
endinterface

// Output channel: one resampled stereo pair per word.
interface sfr_out_if import sfr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          last;

    modport source (output valid, output out_left, output out_right, output last,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input last,
                    output ready);
endinterface

// Configuration write channel.
interface sfr_cfg_if import sfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/stereo_fractional_resampler.sv =====
// Stereo fractional resampler. Each input word carries a signed stereo pair or a restart;
// the block accepts one word at a time and drops ready until that word's work is done.
// Every product goes through one shared 21x18 multiplier. A restart or a priming pair in
// up mode needs no multiplier pass. In up mode each output pair takes one pass per channel.
// In down mode each window segment takes one pass per channel, and each emitted pair takes
// a low and a high pass per channel over the split accumulators. In up mode a pair yields
// 1 to 24 output pairs. A full output register stalls the sequence until it is free.
// Configuration writes are taken at any time.
module stereo_fractional_resampler import sfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_in_if.sink    i_in,
    sfr_out_if.source o_out,
    sfr_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_L,
        ST_UP_R,
        ST_UP_OUT,
        ST_DN_SEG,
        ST_DN_ACCL,
        ST_DN_ACCR,
        ST_EM_LLO,
        ST_EM_LHI,
        ST_EM_RLO,
        ST_EM_RHI,
        ST_EM_RFIN,
        ST_EM_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic              r_down_mode;
    logic [STEP_W-1:0] r_phase_step;
    logic [INV_W-1:0]  r_inv_step;

    // Resampler state.
    logic [PHASE_W-1:0]            r_phase;
    logic                          r_primed;
    logic signed [SAMPLE_BITS-1:0] r_prev_l;
    logic signed [SAMPLE_BITS-1:0] r_prev_r;
    logic signed [ACC_W-1:0]       r_acc_l;
    logic signed [ACC_W-1:0]       r_acc_r;
    logic [REM_W-1:0]              r_remaining;

    // Working registers.
    logic signed [SAMPLE_BITS-1:0] r_cur_l;
    logic signed [SAMPLE_BITS-1:0] r_cur_r;
    logic [PHASE_W-1:0]            r_avail;
    logic [PHASE_W-1:0]            r_take;
    logic signed [WIDE_W-1:0]      r_wide;
    logic signed [SAMPLE_BITS-1:0] r_res_l;

    // Output register.
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;
    logic                          r_out_last;

    // Shared multiplier port.
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [STEP_W-1:0]             eff_step;
    logic signed [SAMPLE_BITS:0]   diff_l;
    logic signed [SAMPLE_BITS:0]   diff_r;
    logic [REM_W-1:0]              rem_eff;
    logic [PHASE_W-1:0]            take;
    logic signed [SAMPLE_BITS-1:0] up_prev;
    logic signed [MUL_P_W-1:0]     up_sum;
    logic signed [SAMPLE_BITS-1:0] up_res;
    logic signed [SAMPLE_BITS-1:0] dn_res;
    logic [REM_W-1:0]              ph_sum;
    logic [REM_W-1:0]              ph_wrap;
    logic                          up_done;
    logic [PHASE_W-1:0]            n_phase;
    logic                          slot_free;
    logic                          in_fire;

    // Clamp a wide signed value to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

    // Divide by one in Q16, rounding toward zero.
    function automatic logic signed [SAT_W-1:0] trunc_q1(
        input logic signed [MUL_P_W-1:0] v
    );
        logic signed [MUL_P_W-1:0] adj;
        adj = v + (v[MUL_P_W-1] ?
              {{(MUL_P_W - PHASE_FRAC_BITS){1'b0}}, {PHASE_FRAC_BITS{1'b1}}} :
              {MUL_P_W{1'b0}});
        return SAT_W'(adj >>> PHASE_FRAC_BITS);
    endfunction

    // Divide by one squared in Q16, rounding toward zero.
    function automatic logic signed [SAT_W-1:0] trunc_q2(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] adj;
        adj = v + (v[WIDE_W-1] ?
              {{SAT_W{1'b0}}, {(2 * PHASE_FRAC_BITS){1'b1}}} :
              {WIDE_W{1'b0}});
        return SAT_W'(adj >>> (2 * PHASE_FRAC_BITS));
    endfunction

    // Steps below the smallest supported ratio are raised to it.
    assign eff_step = (r_phase_step < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : r_phase_step;

    // Interpolation uses prev + (cur - prev) * phase, one product per channel.
    assign diff_l = (SAMPLE_BITS + 1)'(r_cur_l) - (SAMPLE_BITS + 1)'(r_prev_l);
    assign diff_r = (SAMPLE_BITS + 1)'(r_cur_r) - (SAMPLE_BITS + 1)'(r_prev_r);

    // Window bookkeeping for one segment of a down-mode sample.
    assign rem_eff = (r_remaining == '0) ? REM_W'(eff_step) : r_remaining;
    assign take    = (REM_W'(r_avail) < rem_eff) ? r_avail : rem_eff[PHASE_W-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            ST_UP_L: begin
                mul_a = MUL_A_W'(diff_l);
                mul_b = $signed({1'b0, r_phase});
            end
            ST_UP_R: begin
                mul_a = MUL_A_W'(diff_r);
                mul_b = $signed({1'b0, r_phase});
            end
            ST_DN_SEG: begin
                mul_a = MUL_A_W'(r_cur_l);
                mul_b = $signed({1'b0, take});
            end
            ST_DN_ACCL: begin
                mul_a = MUL_A_W'(r_cur_r);
                mul_b = $signed({1'b0, r_take});
            end
            ST_EM_LLO: begin
                mul_a = $signed({1'b0, r_acc_l[ACC_SPLIT-1:0]});
                mul_b = $signed({1'b0, r_inv_step});
            end
            ST_EM_LHI: begin
                mul_a = MUL_A_W'($signed(r_acc_l[ACC_W-1:ACC_SPLIT]));
                mul_b = $signed({1'b0, r_inv_step});
            end
            ST_EM_RLO: begin
                mul_a = $signed({1'b0, r_acc_r[ACC_SPLIT-1:0]});
                mul_b = $signed({1'b0, r_inv_step});
            end
            ST_EM_RHI: begin
                mul_a = MUL_A_W'($signed(r_acc_r[ACC_W-1:ACC_SPLIT]));
                mul_b = $signed({1'b0, r_inv_step});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    sfr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Result arithmetic for both modes.
    assign up_prev = (r_state == ST_UP_R) ? r_prev_l : r_prev_r;
    assign up_sum  = (MUL_P_W'(up_prev) <<< PHASE_FRAC_BITS) + mul_p;
    assign up_res  = sat_sample(trunc_q1(up_sum));
    assign dn_res  = sat_sample(trunc_q2(r_wide));

    // Phase advance after each interpolated pair.
    assign ph_sum  = REM_W'(r_phase) + REM_W'(eff_step);
    assign ph_wrap = ph_sum - REM_W'(ONE_Q);
    assign up_done = ph_sum > REM_W'(ONE_Q);
    always_comb begin
        if (!up_done) begin
            n_phase = ph_sum[PHASE_W-1:0];
        end else if (ph_wrap > REM_W'(ONE_Q)) begin
            n_phase = PHASE_W'(ONE_Q);
        end else begin
            n_phase = ph_wrap[PHASE_W-1:0];
        end
    end

    assign slot_free = !r_out_valid || o_out.ready;
    assign in_fire   = i_in.valid && (r_state == ST_IDLE);

    // Sequencer, state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_down_mode  <= 1'b0;
            r_phase_step <= STEP_W'(STEP_RESET);
            r_inv_step   <= INV_W'(INV_RESET);
            r_phase      <= '0;
            r_primed     <= 1'b0;
            r_prev_l     <= '0;
            r_prev_r     <= '0;
            r_acc_l      <= '0;
            r_acc_r      <= '0;
            r_remaining  <= REM_W'(STEP_RESET);
            r_out_valid  <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_DOWN_MODE:  r_down_mode  <= i_cfg.data[0];
                    CFG_PHASE_STEP: r_phase_step <= i_cfg.data[STEP_W-1:0];
                    CFG_INV_STEP:   r_inv_step   <= i_cfg.data[INV_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_cur_l <= i_in.in_left;
                        r_cur_r <= i_in.in_right;
                        if (i_in.kind == KIND_RESTART) begin
                            r_phase     <= '0;
                            r_primed    <= 1'b0;
                            r_prev_l    <= '0;
                            r_prev_r    <= '0;
                            r_acc_l     <= '0;
                            r_acc_r     <= '0;
                            r_remaining <= REM_W'(eff_step);
                        end else if (r_down_mode) begin
                            r_avail <= PHASE_W'(ONE_Q);
                            r_phase <= '0;
                            r_state <= ST_DN_SEG;
                        end else if (!r_primed) begin
                            r_prev_l <= i_in.in_left;
                            r_prev_r <= i_in.in_right;
                            r_primed <= 1'b1;
                        end else begin
                            r_state <= ST_UP_L;
                        end
                    end
                end
                ST_UP_L: begin
                    r_state <= ST_UP_R;
                end
                ST_UP_R: begin
                    r_res_l <= up_res;
                    r_state <= ST_UP_OUT;
                end
                ST_UP_OUT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_l     <= r_res_l;
                        r_out_r     <= up_res;
                        r_out_last  <= up_done;
                        r_phase     <= n_phase;
                        if (up_done) begin
                            r_prev_l <= r_cur_l;
                            r_prev_r <= r_cur_r;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_state <= ST_UP_L;
                        end
                    end
                end
                ST_DN_SEG: begin
                    r_take      <= take;
                    r_avail     <= r_avail - take;
                    r_remaining <= rem_eff - REM_W'(take);
                    r_state     <= ST_DN_ACCL;
                end
                ST_DN_ACCL: begin
                    r_acc_l <= r_acc_l + ACC_W'(mul_p);
                    r_state <= ST_DN_ACCR;
                end
                ST_DN_ACCR: begin
                    r_acc_r <= r_acc_r + ACC_W'(mul_p);
                    if (r_remaining == '0) begin
                        r_state <= ST_EM_LLO;
                    end else if (r_avail == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_DN_SEG;
                    end
                end
                ST_EM_LLO: begin
                    r_state <= ST_EM_LHI;
                end
                ST_EM_LHI: begin
                    r_wide  <= WIDE_W'(mul_p);
                    r_state <= ST_EM_RLO;
                end
                ST_EM_RLO: begin
                    r_wide  <= r_wide + (WIDE_W'(mul_p) <<< ACC_SPLIT);
                    r_state <= ST_EM_RHI;
                end
                ST_EM_RHI: begin
                    r_res_l <= dn_res;
                    r_wide  <= WIDE_W'(mul_p);
                    r_state <= ST_EM_RFIN;
                end
                ST_EM_RFIN: begin
                    r_wide  <= r_wide + (WIDE_W'(mul_p) <<< ACC_SPLIT);
                    r_state <= ST_EM_OUT;
                end
                ST_EM_OUT: begin
                    if (slot_free) begin
                        // No further window closes in this sample once less than
                        // a full step of it is left.
                        r_out_valid <= 1'b1;
                        r_out_l     <= r_res_l;
                        r_out_r     <= dn_res;
                        r_out_last  <= STEP_W'(r_avail) < eff_step;
                        r_acc_l     <= '0;
                        r_acc_r     <= '0;
                        r_remaining <= REM_W'(eff_step);
                        r_state     <= (r_avail == '0) ? ST_IDLE : ST_DN_SEG;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_left  = r_out_l;
    assign o_out.out_right = r_out_r;
    assign o_out.last      = r_out_last;

endmodule

// ===== design/sfr_mul.sv =====
// Shared signed multiplier with a registered product.
module sfr_mul import sfr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    // The product is captured only when a new operand pair is issued.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ===== design/sfr_checker.sv =====
// Port-level checks for the stereo resampler.
module sfr_checker import sfr_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_kind,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_left,
    input logic signed [SAMPLE_BITS-1:0] i_out_right,
    input logic                          i_out_last
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid after reset");

    // A restart is handled at once and leaves the block ready.
    a_restart_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == KIND_RESTART |=> i_in_ready)
        else $error("block busy after a restart word");

    // An idle block with nothing accepted produces no new word.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && !i_in_valid && (!i_out_valid || i_out_ready) |=> !i_out_valid)
        else $error("output word appeared without an input word");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_left) && $stable(i_out_right)
            && $stable(i_out_last))
        else $error("stalled output word changed");

endmodule

bind stereo_fractional_resampler sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.out_left),
    .i_out_right (o_out.out_right),
    .i_out_last  (o_out.last)
);

// ===== dv/tb_stereo_fractional_resampler.sv =====
`timescale 1ns / 100ps

module tb_stereo_fractional_resampler;
    import sfr_pkg::*;

    localparam longint ONE            = ONE_Q;
    localparam longint SAMPLE_TOP     = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam longint SAMPLE_BOTTOM  = -(2 ** (SAMPLE_BITS - 1));
    localparam int     STEP_MAX       = 1572864;
    localparam int     SETTLE_CYCLES  = 100;
    localparam int     TAIL_CYCLES    = 240;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PHASE_ITEMS    = 35;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          last;
    } t_stereo_pair;

    // Predicts the resampled pairs of every accepted word and checks the block against them.
    class resample_scoreboard;
        bit                down_mode;
        logic [STEP_W-1:0] phase_step;
        logic [INV_W-1:0]  inverse_step;

        longint phase;
        bit     primed;
        longint prev_l;
        longint prev_r;
        longint acc_l;
        longint acc_r;
        longint remaining;

        t_stereo_pair expected_pairs[$];
        int mismatches;
        int words_seen;
        int restarts_seen;
        int down_words;
        int pairs_checked;
        int settings_seen;

        function new();
            down_mode    = 1'b0;
            phase_step   = STEP_W'(STEP_RESET);
            inverse_step = INV_W'(INV_RESET);
            clear_state();
        endfunction

        function longint effective_step();
            longint s;
            s = longint'(phase_step);
            return (s < MIN_STEP) ? longint'(MIN_STEP) : s;
        endfunction

        function void clear_state();
            phase     = 0;
            primed    = 1'b0;
            prev_l    = 0;
            prev_r    = 0;
            acc_l     = 0;
            acc_r     = 0;
            remaining = effective_step();
        endfunction

        function logic signed [SAMPLE_BITS-1:0] clip(longint v);
            if (v > SAMPLE_TOP) return S_MAX;
            if (v < SAMPLE_BOTTOM) return S_MIN;
            return v[SAMPLE_BITS-1:0];
        endfunction

        function void push_pair(longint l, longint r);
            t_stereo_pair p;
            p.left  = clip(l);
            p.right = clip(r);
            p.last  = 1'b0;
            expected_pairs.push_back(p);
        endfunction

        function void apply_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            unique case (idx)
                CFG_DOWN_MODE:  down_mode = data[0];
                CFG_PHASE_STEP: phase_step = data[STEP_W-1:0];
                CFG_INV_STEP: begin
                    inverse_step = data[INV_W-1:0];
                    settings_seen++;
                end
                default: ;
            endcase
        endfunction

        // Works out the pairs that one accepted input word causes.
        function void take_input(logic kind, logic signed [SAMPLE_BITS-1:0] in_l,
                                 logic signed [SAMPLE_BITS-1:0] in_r);
            longint cl, cr, step, w, avail, take, inv;
            int     n;
            cl = longint'(in_l);
            cr = longint'(in_r);
            n  = 0;
            words_seen++;
            if (kind == KIND_RESTART) begin
                restarts_seen++;
                clear_state();
                return;
            end
            step = effective_step();
            if (!down_mode) begin
                // The first pair after a restart only primes the stored pair.
                if (!primed) begin
                    prev_l = cl;
                    prev_r = cr;
                    primed = 1'b1;
                    return;
                end
                forever begin
                    w = ONE - phase;
                    push_pair((prev_l * w + cl * phase) / ONE, (prev_r * w + cr * phase) / ONE);
                    n++;
                    phase += step;
                    if (phase > ONE) begin
                        phase -= ONE;
                        if (phase > ONE) phase = ONE;
                        break;
                    end
                end
                prev_l = cl;
                prev_r = cr;
            end else begin
                // Box average: spread this sample over the windows it covers.
                down_words++;
                avail = ONE;
                inv   = longint'(inverse_step);
                while (avail > 0) begin
                    if (remaining <= 0) remaining = step;
                    take = (avail < remaining) ? avail : remaining;
                    acc_l += cl * take;
                    acc_r += cr * take;
                    avail -= take;
                    remaining -= take;
                    if (remaining == 0) begin
                        push_pair((acc_l * inv) / (ONE * ONE), (acc_r * inv) / (ONE * ONE));
                        n++;
                        acc_l = 0;
                        acc_r = 0;
                        remaining = step;
                    end
                end
                phase = 0;
            end
            if (n > 0) expected_pairs[expected_pairs.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Compares one accepted output word with the oldest expected pair.
        task check_output(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r,
                          logic last);
            t_stereo_pair want;
            pairs_checked++;
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair %0d/%0d last %0b", l, r, last));
                return;
            end
            want = expected_pairs.pop_front();
            if (l !== want.left)
                report_mismatch($sformatf("left %0d, expected %0d", l, want.left));
            if (r !== want.right)
                report_mismatch($sformatf("right %0d, expected %0d", r, want.right));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        endtask

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sfr_in_if  in_if ();
    sfr_out_if out_if ();
    sfr_cfg_if cfg_if ();

    resample_scoreboard sb = new();

    bit gap_on   = 1'b1;
    bit stall_on = 1'b1;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    stereo_fractional_resampler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitors: register writes, output words and input words at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.apply_register(t_cfg_idx'(cfg_if.index), cfg_if.data);
            if (out_if.valid && out_if.ready)
                sb.check_output(out_if.out_left, out_if.out_right, out_if.last);
            if (in_if.valid && in_if.ready)
                sb.take_input(in_if.kind, in_if.in_left, in_if.in_right);
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d pairs still expected",
                     quiet_cycles, sb.pending());
            $display("stereo_fractional_resampler test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output side: random stalls per word, and one long hold-off on request.
    initial begin : receiver
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = stall_on ? $urandom_range(0, 6) : 0;
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // Offers one input word after a random gap and returns at the edge that takes it.
    // Valid stays high so that a back-to-back word needs no second assignment.
    task automatic send_word(logic kind, logic signed [SAMPLE_BITS-1:0] l,
                             logic signed [SAMPLE_BITS-1:0] r);
        int gap;
        gap = gap_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.kind     <= kind;
        in_if.in_left  <= l;
        in_if.in_right <= r;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_pair(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
        send_word(KIND_SAMPLE, l, r);
    endtask

    // One edge first, so that the word taken at the current edge is already predicted.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Writes all three registers once the block has gone idle.
    task automatic write_config(bit mode, int unsigned step, int unsigned inv);
        t_cfg_idx              which[3] = '{CFG_DOWN_MODE, CFG_PHASE_STEP, CFG_INV_STEP};
        logic [CFG_DATA_W-1:0] vals[3];
        in_if.valid <= 1'b0;
        wait_drained();
        // A word that ends no output may still be in progress.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        vals[0] = CFG_DATA_W'(mode);
        vals[1] = CFG_DATA_W'(step);
        vals[2] = CFG_DATA_W'(inv);
        for (int i = 0; i < 3; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= which[i];
            cfg_if.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_BITS'($urandom_range(0, 64) - 32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 5))
            0:       return MIN_STEP;
            1:       return STEP_MAX;
            2:       return $urandom_range(0, MIN_STEP - 1);
            3:       return ONE_Q;
            default: return $urandom_range(MIN_STEP, STEP_MAX);
        endcase
    endfunction

    function automatic int unsigned pick_inv();
        case ($urandom_range(0, 3))
            0:       return MIN_STEP;
            1:       return INV_RESET;
            default: return $urandom_range(MIN_STEP, INV_RESET);
        endcase
    endfunction

    // One register setting followed by random pairs with the odd restart.
    task automatic random_phase(bit mode, int unsigned step, int unsigned inv);
        write_config(mode, step, inv);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_word(KIND_RESTART, pick_sample(), pick_sample());
            else
                send_pair(pick_sample(), pick_sample());
        end
    endtask

    task automatic run_directed();
        // Reset settings: unit step in up mode, priming, extremes and a restart.
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair('0, '0);
        send_pair(-16'sd1, -16'sd1);
        send_pair(S_MAX, S_MAX);
        send_word(KIND_RESTART, S_MIN, S_MAX);
        send_pair(S_MIN, S_MIN);
        send_pair(16'sd1, -16'sd1);

        // A step of zero is raised to the smallest step: the most outputs per pair.
        write_config(1'b0, 0, INV_RESET);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);

        // Largest step in up mode: the phase saturates at one.
        write_config(1'b0, STEP_MAX, INV_RESET);
        send_pair(S_MIN, S_MAX);
        send_pair(S_MAX, S_MIN);
        send_pair(16'sd1234, -16'sd4321);

        // Down mode, three full samples per window, sums past full scale.
        write_config(1'b1, 3 * ONE_Q, INV_RESET);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MAX, S_MIN);

        // Windows of one and a half samples carry a partial sample.
        write_config(1'b1, 3 * ONE_Q / 2, 43690);
        send_pair(16'sd1000, -16'sd1000);
        send_pair(S_MIN, S_MAX);
        send_pair(16'sd12345, -16'sd2);
        send_word(KIND_RESTART, S_MAX, S_MAX);

        // Smallest window and smallest inverse step in down mode.
        write_config(1'b1, MIN_STEP, MIN_STEP);
        send_pair(S_MAX, S_MIN);
    endtask

    // Stimulus: reset, directed words, then random phases under several settings.
    initial begin : stimulus
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.kind      <= KIND_SAMPLE;
        in_if.in_left   <= '0;
        in_if.in_right  <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_DOWN_MODE;
        cfg_if.data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        random_phase(1'b0, MIN_STEP, INV_RESET);
        random_phase(1'b1, $urandom_range(MIN_STEP, 2 * ONE_Q), pick_inv());

        // A stretch with no idling on either side.
        gap_on   = 1'b0;
        stall_on = 1'b0;
        random_phase(1'($urandom_range(0, 1)), pick_step(), pick_inv());
        gap_on   = 1'b1;
        stall_on = 1'b1;

        // Long output hold-off while dense up-mode words keep coming.
        hold_req = 1'b1;
        random_phase(1'b0, MIN_STEP, pick_inv());

        random_phase(1'b1, STEP_MAX, INV_RESET);
        for (int p = 0; p < 3; p++)
            random_phase(1'($urandom_range(0, 1)), pick_step(), pick_inv());

        in_if.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d input words (%0d restarts, %0d in down mode) over %0d settings.",
                 sb.words_seen, sb.restarts_seen, sb.down_words, sb.settings_seen);
        $display("Checked %0d resampled pairs, %0d mismatches, %0d pairs left over.",
                 sb.pairs_checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("stereo_fractional_resampler test passed");
        end else begin
            $display("stereo_fractional_resampler test failed");
        end
        $finish;
    end

endmodule
